// File: rtl/core/ftrk_pkg.sv
// shared types, constants and defaults of the floppy track head engine
`default_nettype none

package ftrk_pkg;

  localparam int CYLINDERS_DEF   = 40;
  localparam int SIDES_DEF       = 2;
  localparam int TRACK_BYTES_DEF = 8192;
  localparam int MARK_SLOTS_DEF  = 64;

  localparam int POS_W     = 14;
  localparam int LEN_W     = POS_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 14;
  localparam int CYL_OUT_W = 6;
  localparam int ENTRY_W   = 16;

  localparam logic [POS_W-1:0] HEAD_START = 14'd128;
  localparam logic [POS_W-1:0] HEAD_MAX   = 14'h3fff;
  localparam logic [7:0]       MARK_BYTE  = 8'hfe;
  localparam logic [13:0]      TLEN_RESET = 14'd6400;

  typedef enum logic [2:0] {
    ACT_READ    = 3'd0,
    ACT_WRITE   = 3'd1,
    ACT_SKIP    = 3'd2,
    ACT_WMARK   = 3'd3,
    ACT_NEXT    = 3'd4,
    ACT_STEP    = 3'd5,
    ACT_ROT     = 3'd6,
    ACT_IDX_END = 3'd7
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DD      = 3'd0,
    CFG_SIDE    = 3'd1,
    CFG_INWARD  = 3'd2,
    CFG_TLEN    = 3'd3,
    CFG_PRESENT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic        dd;
    logic        side;
    logic        inward;
    logic [13:0] tlen;
    logic        present;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_WR2,
    ST_SCAN,
    ST_INSERT,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/ftrk_ifs.sv
// valid/ready channel interfaces for action and result transactions
`default_nettype none

interface ftrk_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] write_byte;
  modport source (output valid, action, write_byte, input ready);
  modport sink (input valid, action, write_byte, output ready);
endinterface

interface ftrk_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic [13:0] head_position;
  logic        mark_found;
  logic        index_active;
  logic        track_zero;
  logic [5:0]  cylinder_now;
  modport source (output valid, read_byte, head_position, mark_found, index_active,
                  track_zero, cylinder_now, input ready);
  modport sink (input valid, read_byte, head_position, mark_found, index_active,
                track_zero, cylinder_now, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ftrk_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
`default_nettype none

module ftrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/ftrk_ctrl.sv
// action sequencer: head state, track byte memory and mark table scan
`default_nettype none

module ftrk_ctrl #(
  parameter int CYLINDERS   = ftrk_pkg::CYLINDERS_DEF,
  parameter int SIDES       = ftrk_pkg::SIDES_DEF,
  parameter int TRACK_BYTES = ftrk_pkg::TRACK_BYTES_DEF,
  parameter int MARK_SLOTS  = ftrk_pkg::MARK_SLOTS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ftrk_pkg::cfg_t cfg,
  ftrk_in_if.sink            in_ch,
  ftrk_out_if.source         out_ch
);

  localparam int PW         = ftrk_pkg::POS_W;
  localparam int LW         = ftrk_pkg::LEN_W;
  localparam int CYL_W      = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
  localparam int TRK_N      = CYLINDERS * SIDES;
  localparam int TRK_W      = (TRK_N > 1) ? $clog2(TRK_N) : 1;
  localparam int BYTE_DEPTH = TRK_N * TRACK_BYTES;
  localparam int BA_W       = $clog2(BYTE_DEPTH);
  localparam int BP_W       = $clog2(TRACK_BYTES);
  localparam int MARK_DEPTH = TRK_N * MARK_SLOTS;
  localparam int MA_W       = $clog2(MARK_DEPTH);
  localparam int SLOT_W     = $clog2(MARK_SLOTS);
  localparam int EW         = ftrk_pkg::ENTRY_W;

  ftrk_pkg::state_t  st_r, st_nxt;
  ftrk_pkg::action_t act_r, act_nxt;
  logic [7:0]        wbyte_r, wbyte_nxt;
  logic [PW-1:0]     head_r, head_nxt;
  logic              idx_r, idx_nxt;
  logic [CYL_W-1:0]  cyl_r, cyl_nxt;
  logic [7:0]        rd_r, rd_nxt;
  logic              found_r, found_nxt;

  logic              ov_r, ov_nxt;
  logic [7:0]        o_rd_r, o_rd_nxt;
  logic [PW-1:0]     o_head_r, o_head_nxt;
  logic              o_found_r, o_found_nxt;
  logic              o_idx_r, o_idx_nxt;
  logic [CYL_W-1:0]  o_cyl_r, o_cyl_nxt;

  logic [BA_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [SLOT_W:0]   scan_cnt_r, scan_cnt_nxt;
  logic              proc_v_r, proc_v_nxt;
  logic [SLOT_W-1:0] proc_slot_r, proc_slot_nxt;
  logic              rm_a_r, rm_a_nxt;
  logic              rm_b_r, rm_b_nxt;
  logic              free_found_r, free_found_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;
  logic [PW-1:0]     max_pos_r, max_pos_nxt;
  logic [SLOT_W-1:0] max_slot_r, max_slot_nxt;
  logic [LW-1:0]     best_r, best_nxt;

  // memory ports
  logic              b_we;
  logic [BA_W-1:0]   b_waddr, b_raddr;
  logic [7:0]        b_wdata, b_rdata;
  logic              m_we;
  logic [MA_W-1:0]   m_waddr, m_raddr;
  logic [EW-1:0]     m_wdata, m_rdata;

  // derived per-item values
  logic              side_eff;
  logic [TRK_W-1:0]  trk;
  logic [BA_W-1:0]   byte_base;
  logic [MA_W-1:0]   mark_base;
  logic [LW-1:0]     len;
  logic [LW-1:0]     head_x;
  logic [LW-1:0]     head_p1;
  logic [LW-1:0]     head_inc;
  logic [PW-1:0]     head_adv;
  logic              head_ok;
  logic              head1_ok;
  logic              span_ok;
  logic              start_scan;

  // scan entry decode
  logic [PW-1:0]     e_pos;
  logic              e_empty;
  logic              e_hit;
  logic [LW-1:0]     best_cur;

  ftrk_ram #(.WIDTH(8), .DEPTH(BYTE_DEPTH)) u_bytes (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  ftrk_ram #(.WIDTH(EW), .DEPTH(MARK_DEPTH)) u_marks (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  always_comb begin
    side_eff  = (SIDES > 1) ? cfg.side : 1'b0;
    trk       = TRK_W'(cyl_r) * TRK_W'(SIDES) + TRK_W'(side_eff);
    byte_base = BA_W'(trk) * BA_W'(TRACK_BYTES);
    mark_base = MA_W'(trk) * MA_W'(MARK_SLOTS);
    len       = (LW'(cfg.tlen) < LW'(TRACK_BYTES)) ? LW'(cfg.tlen) : LW'(TRACK_BYTES);
    head_x    = LW'(head_r);
    head_p1   = head_x + LW'(1);
    head_inc  = head_x + (cfg.dd ? LW'(1) : LW'(2));
    head_adv  = (head_inc > LW'(ftrk_pkg::HEAD_MAX)) ? ftrk_pkg::HEAD_MAX : head_inc[PW-1:0];
    head_ok   = head_x < len;
    head1_ok  = head_p1 < len;
    span_ok   = head_inc < len;

    e_pos     = m_rdata[PW-1:0];
    e_empty   = (e_pos == '0);
    e_hit     = !e_empty && ((rm_a_r && e_pos == head_r) ||
                             (rm_b_r && LW'(e_pos) == head_p1));
    best_cur  = best_r;
    if (proc_v_r && (m_rdata[EW-1] == cfg.dd) && (e_pos > head_r) && (LW'(e_pos) < best_r)) begin
      best_cur = LW'(e_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ftrk_pkg::ST_CLEAR;
      head_r   <= ftrk_pkg::HEAD_START;
      idx_r    <= 1'b0;
      cyl_r    <= '0;
      ov_r     <= 1'b0;
      clr_cnt_r <= '0;
      proc_v_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      head_r   <= head_nxt;
      idx_r    <= idx_nxt;
      cyl_r    <= cyl_nxt;
      ov_r     <= ov_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      proc_v_r <= proc_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    wbyte_r      <= wbyte_nxt;
    rd_r         <= rd_nxt;
    found_r      <= found_nxt;
    o_rd_r       <= o_rd_nxt;
    o_head_r     <= o_head_nxt;
    o_found_r    <= o_found_nxt;
    o_idx_r      <= o_idx_nxt;
    o_cyl_r      <= o_cyl_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    proc_slot_r  <= proc_slot_nxt;
    rm_a_r       <= rm_a_nxt;
    rm_b_r       <= rm_b_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
    max_pos_r    <= max_pos_nxt;
    max_slot_r   <= max_slot_nxt;
    best_r       <= best_nxt;
  end

  always_comb begin
    st_nxt         = st_r;
    act_nxt        = act_r;
    wbyte_nxt      = wbyte_r;
    head_nxt       = head_r;
    idx_nxt        = idx_r;
    cyl_nxt        = cyl_r;
    rd_nxt         = rd_r;
    found_nxt      = found_r;
    ov_nxt         = ov_r;
    o_rd_nxt       = o_rd_r;
    o_head_nxt     = o_head_r;
    o_found_nxt    = o_found_r;
    o_idx_nxt      = o_idx_r;
    o_cyl_nxt      = o_cyl_r;
    clr_cnt_nxt    = clr_cnt_r;
    scan_cnt_nxt   = scan_cnt_r;
    proc_v_nxt     = 1'b0;
    proc_slot_nxt  = proc_slot_r;
    rm_a_nxt       = rm_a_r;
    rm_b_nxt       = rm_b_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    max_pos_nxt    = max_pos_r;
    max_slot_nxt   = max_slot_r;
    best_nxt       = best_r;
    start_scan     = 1'b0;

    b_we    = 1'b0;
    b_waddr = byte_base + BA_W'(head_r[BP_W-1:0]);
    b_wdata = wbyte_r;
    b_raddr = byte_base + BA_W'(head_r[BP_W-1:0]);
    m_we    = 1'b0;
    m_waddr = mark_base + MA_W'(proc_slot_r);
    m_wdata = '0;
    m_raddr = mark_base + MA_W'(scan_cnt_r[SLOT_W-1:0]);

    in_ch.ready = (st_r == ftrk_pkg::ST_IDLE);
    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    unique case (st_r)
      ftrk_pkg::ST_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_cnt_r;
        b_wdata = '0;
        m_we    = (clr_cnt_r < BA_W'(MARK_DEPTH));
        m_waddr = clr_cnt_r[MA_W-1:0];
        m_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + BA_W'(1);
        if (clr_cnt_r == BA_W'(BYTE_DEPTH - 1)) begin
          st_nxt = ftrk_pkg::ST_IDLE;
        end
      end
      ftrk_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          act_nxt   = ftrk_pkg::action_t'(in_ch.action);
          wbyte_nxt = in_ch.write_byte;
          rd_nxt    = '0;
          found_nxt = 1'b0;
          st_nxt    = ftrk_pkg::ST_EXEC;
        end
      end
      ftrk_pkg::ST_EXEC: begin
        st_nxt   = ftrk_pkg::ST_FINISH;
        rm_a_nxt = head_ok;
        rm_b_nxt = !cfg.dd && head1_ok;
        unique case (act_r)
          ftrk_pkg::ACT_READ: begin
            if (cfg.present) begin
              st_nxt = ftrk_pkg::ST_RDWAIT;
            end
          end
          ftrk_pkg::ACT_WRITE: begin
            if (cfg.present) begin
              b_we = head_ok;
              if (!cfg.dd) begin
                st_nxt = ftrk_pkg::ST_WR2;
              end else begin
                start_scan = 1'b1;
              end
            end
          end
          ftrk_pkg::ACT_SKIP: begin
            if (cfg.present) begin
              head_nxt = head_adv;
              idx_nxt  = idx_r | (LW'(head_adv) >= len);
            end
          end
          ftrk_pkg::ACT_WMARK: begin
            if (cfg.present) begin
              if (span_ok) begin
                b_we    = 1'b1;
                b_wdata = ftrk_pkg::MARK_BYTE;
                if (!cfg.dd) begin
                  st_nxt = ftrk_pkg::ST_WR2;
                end else begin
                  start_scan = 1'b1;
                end
              end else begin
                head_nxt = head_adv;
                idx_nxt  = idx_r | (LW'(head_adv) >= len);
              end
            end
          end
          ftrk_pkg::ACT_NEXT: begin
            if (cfg.present) begin
              rm_a_nxt   = 1'b0;
              rm_b_nxt   = 1'b0;
              start_scan = 1'b1;
            end
          end
          ftrk_pkg::ACT_STEP: begin
            if (cfg.present) begin
              if (cfg.inward) begin
                if (cyl_r < CYL_W'(CYLINDERS - 1)) begin
                  cyl_nxt = cyl_r + CYL_W'(1);
                end
              end else if (cyl_r != '0) begin
                cyl_nxt = cyl_r - CYL_W'(1);
              end
            end
          end
          ftrk_pkg::ACT_ROT: begin
            idx_nxt = 1'b1;
            if (cfg.present) begin
              head_nxt = ftrk_pkg::HEAD_START;
            end
          end
          ftrk_pkg::ACT_IDX_END: begin
            idx_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      ftrk_pkg::ST_RDWAIT: begin
        rd_nxt   = head_ok ? b_rdata : 8'd0;
        head_nxt = head_adv;
        idx_nxt  = idx_r | (LW'(head_adv) >= len);
        st_nxt   = ftrk_pkg::ST_FINISH;
      end
      ftrk_pkg::ST_WR2: begin
        b_we       = head1_ok;
        b_waddr    = byte_base + BA_W'(head_p1[BP_W-1:0]);
        b_wdata    = (act_r == ftrk_pkg::ACT_WMARK) ? ftrk_pkg::MARK_BYTE : wbyte_r;
        start_scan = 1'b1;
      end
      ftrk_pkg::ST_SCAN: begin
        // reads run one slot ahead of the decode of the returned entry
        if (scan_cnt_r < (SLOT_W + 1)'(MARK_SLOTS)) begin
          proc_v_nxt    = 1'b1;
          proc_slot_nxt = scan_cnt_r[SLOT_W-1:0];
          scan_cnt_nxt  = scan_cnt_r + (SLOT_W + 1)'(1);
        end
        if (proc_v_r) begin
          m_we     = e_hit;
          best_nxt = best_cur;
          if ((e_empty || e_hit) && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_slot_nxt  = proc_slot_r;
          end
          if (!e_empty && !e_hit && e_pos > max_pos_r) begin
            max_pos_nxt  = e_pos;
            max_slot_nxt = proc_slot_r;
          end
          if (proc_slot_r == SLOT_W'(MARK_SLOTS - 1)) begin
            priority case (act_r)
              ftrk_pkg::ACT_NEXT: begin
                st_nxt = ftrk_pkg::ST_FINISH;
                if (best_cur < len) begin
                  head_nxt  = best_cur[PW-1:0];
                  found_nxt = 1'b1;
                end else begin
                  idx_nxt = 1'b1;
                end
              end
              ftrk_pkg::ACT_WMARK: begin
                st_nxt = ftrk_pkg::ST_INSERT;
              end
              default: begin
                st_nxt   = ftrk_pkg::ST_FINISH;
                head_nxt = head_adv;
                idx_nxt  = idx_r | (LW'(head_adv) >= len);
              end
            endcase
          end
        end
      end
      ftrk_pkg::ST_INSERT: begin
        // a full table loses its highest mark
        m_we     = 1'b1;
        m_waddr  = mark_base + MA_W'(free_found_r ? free_slot_r : max_slot_r);
        m_wdata  = {cfg.dd, 1'b0, head_r};
        head_nxt = head_adv;
        idx_nxt  = idx_r | (LW'(head_adv) >= len);
        st_nxt   = ftrk_pkg::ST_FINISH;
      end
      ftrk_pkg::ST_FINISH: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt      = 1'b1;
          o_rd_nxt    = rd_r;
          o_head_nxt  = head_r;
          o_found_nxt = found_r;
          o_idx_nxt   = idx_r;
          o_cyl_nxt   = cyl_r;
          st_nxt      = ftrk_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = ftrk_pkg::ST_IDLE;
      end
    endcase

    if (start_scan) begin
      st_nxt         = ftrk_pkg::ST_SCAN;
      scan_cnt_nxt   = '0;
      free_found_nxt = 1'b0;
      max_pos_nxt    = '0;
      best_nxt       = len;
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.read_byte     = o_rd_r;
  assign out_ch.head_position = o_head_r;
  assign out_ch.mark_found    = o_found_r;
  assign out_ch.index_active  = o_idx_r;
  assign out_ch.track_zero    = (o_cyl_r == '0);
  assign out_ch.cylinder_now  = ftrk_pkg::CYL_OUT_W'(o_cyl_r);

endmodule

`default_nettype wire

// File: rtl/core/floppy_track_head_engine_core.sv
// Emulated floppy drive head for one drive. After reset the block first clears its track
// byte memory and mark table, one memory word per cycle, over CYLINDERS*SIDES*TRACK_BYTES
// addresses (655360 with the defaults); no action transaction is taken during that pass,
// configuration writes are. Afterwards it takes one action at a time. Step, skip,
// rotation start, index end, a write-mark whose span runs past the track end and any
// action while the drive is not ready go from execution straight to the finish state;
// read first waits for the registered byte memory read; write and next-mark walk the mark
// table, write-mark walks it and then inserts its entry, and a write or write-mark in
// single density writes its second byte before the walk. The walk reads the current
// track's table one slot per cycle through the single read port of the mark memory. The
// next action is taken while the previous result still waits in the output register.
`default_nettype none

module floppy_track_head_engine_core #(
  parameter int CYLINDERS   = ftrk_pkg::CYLINDERS_DEF,
  parameter int SIDES       = ftrk_pkg::SIDES_DEF,
  parameter int TRACK_BYTES = ftrk_pkg::TRACK_BYTES_DEF,
  parameter int MARK_SLOTS  = ftrk_pkg::MARK_SLOTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ftrk_in_if.sink                                in_ch,
  ftrk_out_if.source                             out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [ftrk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ftrk_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  ftrk_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (ftrk_pkg::cfg_idx_t'(cfg_index))
        ftrk_pkg::CFG_DD:      cfg_nxt.dd      = cfg_wdata[0];
        ftrk_pkg::CFG_SIDE:    cfg_nxt.side    = cfg_wdata[0];
        ftrk_pkg::CFG_INWARD:  cfg_nxt.inward  = cfg_wdata[0];
        ftrk_pkg::CFG_TLEN:    cfg_nxt.tlen    = cfg_wdata[13:0];
        ftrk_pkg::CFG_PRESENT: cfg_nxt.present = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dd      <= 1'b1;
      cfg_r.side    <= 1'b0;
      cfg_r.inward  <= 1'b1;
      cfg_r.tlen    <= ftrk_pkg::TLEN_RESET;
      cfg_r.present <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ftrk_ctrl #(
    .CYLINDERS   (CYLINDERS),
    .SIDES       (SIDES),
    .TRACK_BYTES (TRACK_BYTES),
    .MARK_SLOTS  (MARK_SLOTS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// File: rtl/core/ftrk_checker.sv
// port-level assertions for the head engine and their bind to the top level
`default_nettype none

module ftrk_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [7:0]  out_read_byte,
  input wire logic [13:0] out_head_position,
  input wire logic        out_mark_found,
  input wire logic        out_track_zero,
  input wire logic [5:0]  out_cylinder_now
);

  // a held result keeps its head position and read byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_head_position)
      && $stable(out_read_byte))
    else $error("result changed while stalled");

  // one action at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second action taken while one is in flight");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_track_zero == (out_cylinder_now == 6'd0)))
    else $error("track zero flag disagrees with cylinder");

  a_found_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mark_found |-> out_read_byte == 8'd0)
    else $error("mark search returned read data");

  // head never moves before the start of the data area
  a_head_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_head_position >= ftrk_pkg::HEAD_START)
    else $error("head below start position");

endmodule

bind floppy_track_head_engine_core ftrk_checker u_ftrk_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_read_byte     (out_ch.read_byte),
  .out_head_position (out_ch.head_position),
  .out_mark_found    (out_ch.mark_found),
  .out_track_zero    (out_ch.track_zero),
  .out_cylinder_now  (out_ch.cylinder_now)
);

`default_nettype wire

// File: tb/floppy_track_head_engine_core_tb.sv
// testbench of the floppy track head engine: directed and random action transactions
`timescale 1ns / 100ps

module floppy_track_head_engine_core_tb;

  localparam int NCYL  = 40;
  localparam int NSLOT = 64;
  localparam int TBYTES = 8192;

  typedef struct {
    logic [7:0]  read_byte;
    logic [13:0] head_position;
    logic        mark_found;
    logic        index_active;
    logic        track_zero;
    logic [5:0]  cylinder_now;
  } head_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ftrk_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ftrk_pkg::CFG_DAT_W-1:0] cfg_wdata;

  ftrk_in_if  in_ch ();
  ftrk_out_if out_ch ();

  floppy_track_head_engine_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // drive mirror
  logic [7:0]  byte_store [int];
  logic [15:0] mark_tab [NCYL*2][NSLOT];
  int          cyl;
  int          head;
  logic        idx_flag;
  logic        m_dd, m_side, m_inward, m_present;
  int          m_tlen;

  head_result_t pending_results[$];
  int errors;
  int send_gap_pct;
  int stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("floppy_track_head_engine_core_tb NOT OK");
    $finish;
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    head_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.read_byte !== e.read_byte) begin
          $error("read_byte exp %0d got %0d", e.read_byte, out_ch.read_byte); errors++;
        end
        if (out_ch.head_position !== e.head_position) begin
          $error("head_position exp %0d got %0d", e.head_position, out_ch.head_position);
          errors++;
        end
        if (out_ch.mark_found !== e.mark_found) begin
          $error("mark_found exp %0d got %0d", e.mark_found, out_ch.mark_found); errors++;
        end
        if (out_ch.index_active !== e.index_active) begin
          $error("index_active exp %0d got %0d", e.index_active, out_ch.index_active);
          errors++;
        end
        if (out_ch.track_zero !== e.track_zero) begin
          $error("track_zero exp %0d got %0d", e.track_zero, out_ch.track_zero); errors++;
        end
        if (out_ch.cylinder_now !== e.cylinder_now) begin
          $error("cylinder_now exp %0d got %0d", e.cylinder_now, out_ch.cylinder_now);
          errors++;
        end
      end
    end
  end

  function automatic int mark_key(logic [15:0] ent);
    return (ent[13:0] != 0) ? int'(ent[13:0]) : 16384;
  endfunction

  // stable insertion sort, empty entries last
  function automatic void sort_track_marks(int trk);
    logic [15:0] v;
    int j;
    for (int i = 1; i < NSLOT; i++) begin
      v = mark_tab[trk][i];
      j = i;
      while (j > 0 && mark_key(mark_tab[trk][j-1]) > mark_key(v)) begin
        mark_tab[trk][j] = mark_tab[trk][j-1];
        j--;
      end
      mark_tab[trk][j] = v;
    end
  endfunction

  function automatic void clear_marks_at(int trk, int pos);
    for (int k = 0; k < NSLOT; k++)
      if (int'(mark_tab[trk][k][13:0]) == pos) mark_tab[trk][k] = '0;
  endfunction

  function automatic void move_head(int n);
    head += n;
    if (head > 16383) head = 16383;
  endfunction

  function automatic head_result_t predict_head_action(ftrk_pkg::action_t act,
                                                       logic [7:0] wbyte);
    head_result_t r;
    int trk, len, inc, best, p;
    logic [7:0] rd;
    logic found;
    trk = cyl * 2 + m_side;
    len = (m_tlen < TBYTES) ? m_tlen : TBYTES;
    inc = m_dd ? 1 : 2;
    rd = 8'd0;
    found = 1'b0;
    case (act)
      ftrk_pkg::ACT_READ, ftrk_pkg::ACT_WRITE, ftrk_pkg::ACT_SKIP,
      ftrk_pkg::ACT_WMARK: begin
        if (m_present) begin
          if (act == ftrk_pkg::ACT_READ) begin
            if (head < len && byte_store.exists(trk * TBYTES + head))
              rd = byte_store[trk * TBYTES + head];
            move_head(inc);
          end else if (act == ftrk_pkg::ACT_WRITE) begin
            for (int i = 0; i < inc; i++) begin
              if (head < len) begin
                byte_store[trk * TBYTES + head] = wbyte;
                clear_marks_at(trk, head);
                sort_track_marks(trk);
              end
              move_head(1);
            end
          end else if (act == ftrk_pkg::ACT_WMARK) begin
            if (head + inc < len) begin
              for (int i = 0; i < inc; i++) begin
                p = head + i;
                byte_store[trk * TBYTES + p] = ftrk_pkg::MARK_BYTE;
                clear_marks_at(trk, p);
              end
              sort_track_marks(trk);
              mark_tab[trk][NSLOT-1] = {m_dd, 1'b0, 14'(head)};
              sort_track_marks(trk);
            end
            move_head(inc);
          end else begin
            move_head(inc);
          end
          if (head >= len) idx_flag = 1'b1;
        end
      end
      ftrk_pkg::ACT_NEXT: begin
        if (m_present) begin
          best = len;
          for (int i = 0; i < NSLOT; i++) begin
            p = mark_tab[trk][i][13:0];
            if (mark_tab[trk][i][15] == m_dd && head < p && p < best) best = p;
          end
          if (best >= len) idx_flag = 1'b1;
          else begin
            head = best;
            found = 1'b1;
          end
        end
      end
      ftrk_pkg::ACT_STEP: begin
        if (m_present) begin
          if (m_inward) begin
            if (cyl < NCYL - 1) cyl++;
          end else if (cyl > 0) begin
            cyl--;
          end
        end
      end
      ftrk_pkg::ACT_ROT: begin
        idx_flag = 1'b1;
        if (m_present) head = ftrk_pkg::HEAD_START;
      end
      default: idx_flag = 1'b0;
    endcase
    r.read_byte = rd;
    r.head_position = 14'(head);
    r.mark_found = found;
    r.index_active = idx_flag;
    r.track_zero = (cyl == 0);
    r.cylinder_now = 6'(cyl);
    return r;
  endfunction

  task automatic send_action(ftrk_pkg::action_t act, logic [7:0] wbyte);
    int gap;
    gap = 0;
    if (send_gap_pct > 0)
      while ($urandom_range(99) < send_gap_pct && gap < 20) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.write_byte = wbyte;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_head_action(act, wbyte));
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (pending_results.size() == 0);
    // let the design idle before the next register write
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(ftrk_pkg::cfg_idx_t idx, int val);
    drain_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = ftrk_pkg::CFG_DAT_W'(val);
    case (idx)
      ftrk_pkg::CFG_DD:      m_dd = val[0];
      ftrk_pkg::CFG_SIDE:    m_side = val[0];
      ftrk_pkg::CFG_INWARD:  m_inward = val[0];
      ftrk_pkg::CFG_TLEN:    m_tlen = val & 16'h3fff;
      ftrk_pkg::CFG_PRESENT: m_present = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_bad_index(logic [ftrk_pkg::CFG_IDX_W-1:0] idx, int val);
    drain_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = ftrk_pkg::CFG_DAT_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_not_ready();
    write_reg(ftrk_pkg::CFG_PRESENT, 0);
    for (int a = 0; a < 8; a++) send_action(ftrk_pkg::action_t'(a), 8'hff);
    send_action(ftrk_pkg::ACT_IDX_END, 8'h00);
  endtask

  task automatic test_basic_actions();
    write_reg(ftrk_pkg::CFG_PRESENT, 1);
    send_action(ftrk_pkg::ACT_WRITE, 8'h5a);
    send_action(ftrk_pkg::ACT_WMARK, 8'h00);
    send_action(ftrk_pkg::ACT_ROT, 8'h00);
    send_action(ftrk_pkg::ACT_READ, 8'h00);
    send_action(ftrk_pkg::ACT_NEXT, 8'h00);
    send_action(ftrk_pkg::ACT_READ, 8'h00);
    send_action(ftrk_pkg::ACT_IDX_END, 8'h00);
    send_action(ftrk_pkg::ACT_NEXT, 8'h00);
    write_reg(ftrk_pkg::CFG_DD, 0);
    send_action(ftrk_pkg::ACT_ROT, 8'h00);
    send_action(ftrk_pkg::ACT_WRITE, 8'ha5);
    send_action(ftrk_pkg::ACT_WMARK, 8'h00);
    send_action(ftrk_pkg::ACT_ROT, 8'h00);
    send_action(ftrk_pkg::ACT_NEXT, 8'h00);
    // overwrite the mark just found
    send_action(ftrk_pkg::ACT_WRITE, 8'h00);
    send_action(ftrk_pkg::ACT_ROT, 8'h00);
    send_action(ftrk_pkg::ACT_NEXT, 8'h00);
    write_reg(ftrk_pkg::CFG_INWARD, 0);
    send_action(ftrk_pkg::ACT_STEP, 8'h00);
    write_reg(ftrk_pkg::CFG_INWARD, 1);
    for (int i = 0; i < 42; i++) send_action(ftrk_pkg::ACT_STEP, 8'h00);
    write_reg(ftrk_pkg::CFG_SIDE, 1);
    send_action(ftrk_pkg::ACT_READ, 8'h00);
    write_reg(ftrk_pkg::CFG_INWARD, 0);
    for (int i = 0; i < 40; i++) send_action(ftrk_pkg::ACT_STEP, 8'h00);
  endtask

  task automatic test_track_length_extremes();
    write_reg(ftrk_pkg::CFG_TLEN, 129);
    send_action(ftrk_pkg::ACT_ROT, 8'h00);
    send_action(ftrk_pkg::ACT_WMARK, 8'h11);
    send_action(ftrk_pkg::ACT_READ, 8'h00);
    send_action(ftrk_pkg::ACT_READ, 8'h00);
    send_action(ftrk_pkg::ACT_WRITE, 8'h22);
    write_reg(ftrk_pkg::CFG_TLEN, 16383);
    write_bad_index(3'd5, 200);
    write_bad_index(3'd7, 0);
    send_action(ftrk_pkg::ACT_ROT, 8'h00);
    send_action(ftrk_pkg::ACT_READ, 8'h00);
    send_action(ftrk_pkg::ACT_NEXT, 8'h00);
  endtask

  task automatic test_past_track_end();
    write_reg(ftrk_pkg::CFG_DD, 0);
    write_reg(ftrk_pkg::CFG_TLEN, 131);
    send_action(ftrk_pkg::ACT_ROT, 8'h00);
    send_action(ftrk_pkg::ACT_IDX_END, 8'h00);
    send_action(ftrk_pkg::ACT_SKIP, 8'h00);
    send_action(ftrk_pkg::ACT_SKIP, 8'h00);
    send_action(ftrk_pkg::ACT_WRITE, 8'h77);
    send_action(ftrk_pkg::ACT_WMARK, 8'h00);
    send_action(ftrk_pkg::ACT_READ, 8'h00);
    send_action(ftrk_pkg::ACT_NEXT, 8'h00);
  endtask

  function automatic ftrk_pkg::action_t pick_action();
    int w;
    w = $urandom_range(99);
    if (w < 18) return ftrk_pkg::ACT_READ;
    if (w < 36) return ftrk_pkg::ACT_WRITE;
    if (w < 48) return ftrk_pkg::ACT_SKIP;
    if (w < 62) return ftrk_pkg::ACT_WMARK;
    if (w < 78) return ftrk_pkg::ACT_NEXT;
    if (w < 83) return ftrk_pkg::ACT_STEP;
    if (w < 94) return ftrk_pkg::ACT_ROT;
    return ftrk_pkg::ACT_IDX_END;
  endfunction

  task automatic test_random_traffic();
    int gaps[4] = '{0, 64, 0, 34};
    int stalls[4] = '{0, 0, 64, 34};
    int lens[4] = '{129, 8192, 300, 16383};
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct = gaps[ph];
      stall_pct = stalls[ph];
      for (int sub = 0; sub < 3; sub++) begin
        write_reg(ftrk_pkg::CFG_DD, $urandom_range(1));
        write_reg(ftrk_pkg::CFG_SIDE, $urandom_range(1));
        write_reg(ftrk_pkg::CFG_INWARD, $urandom_range(1));
        write_reg(ftrk_pkg::CFG_TLEN, (sub == 0) ? lens[ph] : $urandom_range(129, 600));
        write_reg(ftrk_pkg::CFG_PRESENT, ($urandom_range(9) != 0));
        send_action(ftrk_pkg::ACT_ROT, 8'h00);
        for (int i = 0; i < 66; i++) send_action(pick_action(), 8'($urandom));
      end
      if (ph == 1) drain_results();
    end
    stall_pct = 0;
    send_gap_pct = 0;
  endtask

  initial begin
    errors = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ftrk_pkg::ACT_READ;
    in_ch.write_byte = 8'h00;
    out_ch.ready = 1'b1;
    cyl = 0;
    head = ftrk_pkg::HEAD_START;
    idx_flag = 1'b0;
    m_dd = 1'b1;
    m_side = 1'b0;
    m_inward = 1'b1;
    m_tlen = ftrk_pkg::TLEN_RESET;
    m_present = 1'b0;
    for (int t = 0; t < NCYL * 2; t++)
      for (int k = 0; k < NSLOT; k++) mark_tab[t][k] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_not_ready();
    test_basic_actions();
    test_track_length_extremes();
    test_random_traffic();
    test_past_track_end();
    drain_results();

    if (errors == 0) begin
      $display("floppy_track_head_engine_core_tb OK");
    end else begin
      $display("floppy_track_head_engine_core_tb NOT OK");
    end
    $finish;
  end

endmodule
